>>> rtl/core/assert_macros.svh
// Assertion helpers used by the converter core to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/m2mec_pkg.sv
`default_nettype none
package m2mec_pkg;

  // Sizes
  localparam int CHANNEL_COUNT        = 16;
  localparam int CH_W                 = 4;
  localparam int DELAY_BYTES_MAX_DEF  = 4;
  localparam int DELAY_W_MAX          = 28;
  localparam int QUEUE_DEPTH          = 2;

  // MUS event types
  localparam logic [2:0] MUS_RELEASE = 3'd0;
  localparam logic [2:0] MUS_PLAY    = 3'd1;
  localparam logic [2:0] MUS_PITCH   = 3'd2;
  localparam logic [2:0] MUS_SYSTEM  = 3'd3;
  localparam logic [2:0] MUS_CTRL    = 3'd4;
  localparam logic [2:0] MUS_BAD_A   = 3'd5;
  localparam logic [2:0] MUS_END     = 3'd6;
  localparam logic [2:0] MUS_BAD_B   = 3'd7;

  // MIDI bytes
  localparam logic [3:0] MIDI_NOTE_OFF = 4'h8;
  localparam logic [3:0] MIDI_NOTE_ON  = 4'h9;
  localparam logic [3:0] MIDI_CTRL     = 4'hB;
  localparam logic [3:0] MIDI_PROGRAM  = 4'hC;
  localparam logic [3:0] MIDI_PITCH    = 4'hE;
  localparam logic [7:0] MIDI_META     = 8'hFF;
  localparam logic [7:0] META_END      = 8'h2F;
  localparam logic [7:0] CC_VOLUME     = 8'h07;
  localparam logic [7:0] VOLUME_MAX    = 8'd127;
  localparam logic [7:0] OFF_VELOCITY  = 8'h40;
  localparam logic [7:0] VOLUME_RESET  = 8'd64;
  localparam logic [7:0] SYS_MONO      = 8'd12;
  localparam logic [7:0] CTRL_LIMIT    = 8'd15;

  localparam logic [CH_W-1:0] MUS_PERC_CH  = 4'd15;
  localparam logic [CH_W-1:0] MIDI_PERC_CH = 4'd9;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_TYPE = 2'd1;
  localparam logic [1:0] ERR_CTRL = 2'd2;

  typedef enum logic [1:0] {
    PH_EVENT,
    PH_DATA1,
    PH_DATA2,
    PH_DELAY
  } phase_e;

  typedef enum logic [1:0] {
    JOB_EVENT,
    JOB_ERR_TYPE,
    JOB_ERR_CTRL
  } job_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELAY,
    ST_VOL,
    ST_EVT,
    ST_ERR
  } stage_e;

  // One classified event handed from front to back
  typedef struct packed {
    job_kind_e        kind;
    logic             new_chan;
    logic [CH_W-1:0]  vol_chan;
    logic [7:0]       status;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic             three;
  } job_t;

  // MUS controller number to MIDI controller number
  function automatic logic [7:0] ctrl_lookup(input logic [7:0] idx);
    logic [7:0] r;
    unique case (idx)
      8'd0:    r = 8'h00;
      8'd1:    r = 8'h00;
      8'd2:    r = 8'h01;
      8'd3:    r = 8'h07;
      8'd4:    r = 8'h0A;
      8'd5:    r = 8'h0B;
      8'd6:    r = 8'h5B;
      8'd7:    r = 8'h5D;
      8'd8:    r = 8'h40;
      8'd9:    r = 8'h43;
      8'd10:   r = 8'h78;
      8'd11:   r = 8'h7B;
      8'd12:   r = 8'h7E;
      8'd13:   r = 8'h7F;
      8'd14:   r = 8'h79;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/mus_to_midi_event_converter_core.sv
// MUS score bytes in, MIDI track event bytes out. A front parser takes one
// score byte per cycle whenever its two-entry event queue has room, tracks
// the channel map, note volumes and pending delay, and queues each finished
// event. A back sequencer emits one MIDI byte per cycle from the queue
// whenever its output register is empty or popped: the delta (1 to 4 bytes),
// a volume message on a channel's first use (4 bytes) and the event (2 or 3
// bytes), so each event comes out as 3 to 11 bytes. An idle sequencer first
// loads a queued event into its job register. Errors come out as one zero
// byte with an error code and last_of_run set. No clearing pass runs after
// reset. Configuration must be written while idle; the block has no guard.
`default_nettype none
`include "assert_macros.svh"
module mus_to_midi_event_converter_core import m2mec_pkg::*; #(
  parameter int DelayBytesMax = DELAY_BYTES_MAX_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] score_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      midi_byte_o,
  output logic            last_of_run_o,
  output logic [1:0]      error_code_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [3:0] mus_channel_count_i
);

  localparam int DelayW = (7 * DelayBytesMax > DELAY_W_MAX) ? DELAY_W_MAX : 7 * DelayBytesMax;
  localparam int QW     = DelayW + $bits(job_t);

  logic              q_ready, q_push, q_valid, q_pop;
  job_t              f_job, b_job;
  logic [DelayW-1:0] f_delay, b_delay;
  logic [QW-1:0]     q_rdata;

  assign cfg_ready_o = 1'b1;

  m2mec_front #(.DelayBytesMax(DelayBytesMax)) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push_i              (push),
    .score_byte_i        (score_byte_i),
    .ready_i             (q_ready),
    .cfg_valid_i         (cfg_valid_i),
    .mus_channel_count_i (mus_channel_count_i),
    .full_o              (full),
    .job_valid_o         (q_push),
    .job_o               (f_job),
    .job_delay_o         (f_delay)
  );

  m2mec_queue #(.Width(QW)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i ({f_delay, f_job}),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  assign b_delay = q_rdata[QW-1 -: DelayW];
  assign b_job   = q_rdata[$bits(job_t)-1:0];

  m2mec_back #(.DelayBytesMax(DelayBytesMax)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (b_job),
    .job_delay_i   (b_delay),
    .job_pop_o     (q_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .midi_byte_o   (midi_byte_o),
    .last_of_run_o (last_of_run_o),
    .error_code_o  (error_code_o)
  );

  // Error results are single zero bytes that close their run
  `ASSERT_SAME(a_err_last, clk_i, rst_ni, !empty && (error_code_o != ERR_NONE), last_of_run_o && (midi_byte_o == 8'd0), "error result not a closing zero byte")
  // The front never queues an event without room
  `ASSERT_SAME(a_q_room, clk_i, rst_ni, q_push, q_ready, "event queued while queue full")
  // No undefined error code reaches the output
  `ASSERT_SAME(a_err_code, clk_i, rst_ni, !empty, error_code_o <= ERR_CTRL, "undefined error code")
  // A popped queue entry always sets the sequencer going
  `ASSERT_NEXT(a_pop_fills, clk_i, rst_ni, q_pop && q_valid, u_back.st_q != ST_IDLE, "queued event not taken up")

endmodule
`default_nettype wire

>>> rtl/core/m2mec_queue.sv
`default_nettype none
module m2mec_queue import m2mec_pkg::*; #(
  parameter int Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic                  ready_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output logic [Width-1:0]      rdata_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [Width-1:0] mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  assign ready_o = (count_q != CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Store an item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/m2mec_front.sv
`default_nettype none
module m2mec_front import m2mec_pkg::*; #(
  parameter int DelayBytesMax = DELAY_BYTES_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire logic [7:0]  score_byte_i,
  input  wire logic        ready_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [3:0]  mus_channel_count_i,
  output logic             full_o,
  output logic             job_valid_o,
  output job_t             job_o,
  output logic [((7*DelayBytesMax > DELAY_W_MAX) ? DELAY_W_MAX : 7*DelayBytesMax)-1:0]
                           job_delay_o
);

  localparam int DelayW = (7 * DelayBytesMax > DELAY_W_MAX) ? DELAY_W_MAX : 7 * DelayBytesMax;

  phase_e            phase_q, phase_d;
  logic [7:0]        held_event_q, held_event_d;
  logic [7:0]        held_d1_q, held_d1_d;
  logic [4:0]        map_q [CHANNEL_COUNT];
  logic [7:0]        vol_q [CHANNEL_COUNT];
  logic [4:0]        next_free_q, next_free_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [3:0]        chan_count_q;

  logic              accept;
  logic              do_emit;
  logic [7:0]        ev_s, d1_s, sec_s;
  logic [2:0]        type_s;
  logic [CH_W-1:0]   ch_s, m_s;
  logic              unmapped;
  logic              map_we, vol_we;
  logic [4:0]        nf_inc;
  logic [DelayW+6:0] acc;

  assign accept = push_i && ready_i;
  assign full_o = !ready_i;

  // Pick the event, first data and second data for an event that completes now
  always_comb begin
    ev_s  = held_event_q;
    d1_s  = held_d1_q;
    sec_s = 8'd0;
    unique case (phase_q)
      PH_EVENT: ev_s  = score_byte_i;
      PH_DATA1: d1_s  = score_byte_i;
      PH_DATA2: sec_s = score_byte_i;
      PH_DELAY: ;
    endcase
  end

  assign type_s   = ev_s[6:4];
  assign ch_s     = ev_s[3:0];
  assign unmapped = map_q[ch_s][4];
  assign m_s      = unmapped ? next_free_q[CH_W-1:0] : map_q[ch_s][CH_W-1:0];
  assign nf_inc   = next_free_q + 5'd1;
  assign acc      = {delay_q, score_byte_i[6:0]};

  // Parse the byte, update the phase and build the job
  always_comb begin
    phase_d      = phase_q;
    held_event_d = held_event_q;
    held_d1_d    = held_d1_q;
    next_free_d  = next_free_q;
    delay_d      = delay_q;
    do_emit      = 1'b0;
    job_valid_o  = 1'b0;
    job_o        = '0;
    job_o.kind   = JOB_EVENT;
    map_we       = 1'b0;
    vol_we       = 1'b0;

    if (accept) begin
      unique case (phase_q)
        PH_DELAY: begin
          // Accumulate and saturate the delay
          delay_d = (acc[DelayW+6:DelayW] != '0) ? '1 : acc[DelayW-1:0];
          if (!score_byte_i[7]) begin
            phase_d = PH_EVENT;
          end
        end
        PH_EVENT: begin
          if (type_s == MUS_BAD_A || type_s == MUS_BAD_B) begin
            job_valid_o = 1'b1;
            job_o.kind  = JOB_ERR_TYPE;
          end else begin
            held_event_d = score_byte_i;
            if (type_s == MUS_END) begin
              do_emit = 1'b1;
            end else begin
              phase_d = PH_DATA1;
            end
          end
        end
        PH_DATA1: begin
          held_d1_d = score_byte_i;
          if (type_s == MUS_PLAY) begin
            if (score_byte_i[7]) begin
              phase_d = PH_DATA2;
            end else begin
              do_emit = 1'b1;
            end
          end else if (type_s == MUS_SYSTEM || type_s == MUS_CTRL) begin
            if (type_s == MUS_CTRL && score_byte_i == 8'd0) begin
              phase_d = PH_DATA2;
            end else if (score_byte_i >= CTRL_LIMIT) begin
              job_valid_o = 1'b1;
              job_o.kind  = JOB_ERR_CTRL;
              phase_d     = PH_EVENT;
            end else begin
              phase_d = PH_DATA2;
            end
          end else begin
            do_emit = 1'b1;
          end
        end
        PH_DATA2: do_emit = 1'b1;
      endcase
    end

    // Complete an event: allocate the channel and form the MIDI message
    if (do_emit) begin
      job_valid_o    = 1'b1;
      job_o.kind     = JOB_EVENT;
      job_o.new_chan = unmapped;
      job_o.vol_chan = next_free_q[CH_W-1:0];
      job_o.three    = 1'b1;
      delay_d        = '0;
      phase_d        = ev_s[7] ? PH_DELAY : PH_EVENT;
      if (unmapped) begin
        map_we      = 1'b1;
        next_free_d = (nf_inc == 5'({1'b0, MIDI_PERC_CH})) ? nf_inc + 5'd1 : nf_inc;
      end
      case (type_s)
        MUS_RELEASE: begin
          job_o.status = {MIDI_NOTE_OFF, m_s};
          job_o.b1     = d1_s;
          job_o.b2     = OFF_VELOCITY;
        end
        MUS_PLAY: begin
          vol_we       = d1_s[7];
          job_o.status = {MIDI_NOTE_ON, m_s};
          job_o.b1     = {1'b0, d1_s[6:0]};
          job_o.b2     = d1_s[7] ? sec_s : vol_q[m_s];
        end
        MUS_PITCH: begin
          job_o.status = {MIDI_PITCH, m_s};
          job_o.b1     = {1'b0, d1_s[0], 6'd0};
          job_o.b2     = {1'b0, d1_s[7:1]};
        end
        MUS_SYSTEM: begin
          job_o.status = {MIDI_CTRL, m_s};
          job_o.b1     = ctrl_lookup(d1_s);
          job_o.b2     = (sec_s == SYS_MONO) ? {4'd0, chan_count_q} + 8'd1 : 8'd0;
        end
        MUS_CTRL: begin
          if (d1_s == 8'd0) begin
            job_o.status = {MIDI_PROGRAM, m_s};
            job_o.b1     = sec_s;
            job_o.b2     = 8'd0;
            job_o.three  = 1'b0;
          end else begin
            job_o.status = {MIDI_CTRL, m_s};
            job_o.b1     = ctrl_lookup(d1_s);
            job_o.b2     = sec_s;
          end
        end
        default: begin
          job_o.status = MIDI_META;
          job_o.b1     = META_END;
          job_o.b2     = 8'd0;
        end
      endcase
    end
  end

  assign job_delay_o = delay_q;

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_EVENT;
      held_event_q <= 8'd0;
      held_d1_q    <= 8'd0;
      next_free_q  <= 5'd0;
      delay_q      <= '0;
      chan_count_q <= 4'd0;
    end else begin
      phase_q      <= phase_d;
      held_event_q <= held_event_d;
      held_d1_q    <= held_d1_d;
      next_free_q  <= next_free_d;
      delay_q      <= delay_d;
      if (cfg_valid_i) begin
        chan_count_q <= mus_channel_count_i;
      end
    end
  end

  // Hold channel map and note volumes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        map_q[i] <= 5'h10;
        vol_q[i] <= VOLUME_RESET;
      end
      map_q[MUS_PERC_CH] <= {1'b0, MIDI_PERC_CH};
    end else begin
      if (map_we) begin
        map_q[ch_s] <= {1'b0, next_free_q[CH_W-1:0]};
      end
      if (vol_we) begin
        vol_q[m_s] <= sec_s;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/m2mec_back.sv
`default_nettype none
module m2mec_back import m2mec_pkg::*; #(
  parameter int DelayBytesMax = DELAY_BYTES_MAX_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  input  wire job_t        job_i,
  input  wire logic [((7*DelayBytesMax > DELAY_W_MAX) ? DELAY_W_MAX : 7*DelayBytesMax)-1:0]
                           job_delay_i,
  output logic             job_pop_o,
  input  wire logic        pop_i,
  output logic             empty_o,
  output logic [7:0]       midi_byte_o,
  output logic             last_of_run_o,
  output logic [1:0]       error_code_o
);

  localparam int DelayW = (7 * DelayBytesMax > DELAY_W_MAX) ? DELAY_W_MAX : 7 * DelayBytesMax;
  localparam int Groups = (DelayW + 6) / 7;
  localparam int GrpW   = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int PadW   = 7 * (2 ** GrpW);

  stage_e            st_q, st_d;
  job_t              job_q, job_d;
  logic [DelayW-1:0] delay_q, delay_d;
  logic [GrpW-1:0]   grp_q, grp_d;
  logic [1:0]        pos_q, pos_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [1:0]        out_err_q, out_err_d;

  logic [PadW-1:0]   pad_in, pad_cur;
  logic [GrpW-1:0]   top_grp;
  logic              out_ready, emit, load;
  logic [7:0]        cur_byte;
  logic              cur_last;
  logic [1:0]        cur_err;

  assign pad_in  = {{(PadW - DelayW){1'b0}}, job_delay_i};
  assign pad_cur = {{(PadW - DelayW){1'b0}}, delay_q};

  // Find the highest nonzero 7-bit delay group
  always_comb begin
    top_grp = '0;
    for (int g = 1; g < 2 ** GrpW; g++) begin
      if (pad_in[7*g +: 7] != 7'd0) begin
        top_grp = GrpW'(g);
      end
    end
  end

  // Select the byte of the current step
  always_comb begin
    cur_byte = 8'd0;
    cur_last = 1'b0;
    cur_err  = ERR_NONE;
    unique case (st_q)
      ST_IDLE: ;
      ST_DELAY: cur_byte = {grp_q != '0, pad_cur[7*grp_q +: 7]};
      ST_VOL: begin
        unique case (pos_q)
          2'd0: cur_byte = {MIDI_CTRL, job_q.vol_chan};
          2'd1: cur_byte = CC_VOLUME;
          2'd2: cur_byte = VOLUME_MAX;
          2'd3: cur_byte = 8'd0;
        endcase
      end
      ST_EVT: begin
        unique case (pos_q)
          2'd0:    cur_byte = job_q.status;
          2'd1:    cur_byte = job_q.b1;
          default: cur_byte = job_q.b2;
        endcase
        cur_last = (pos_q == (job_q.three ? 2'd2 : 2'd1));
      end
      ST_ERR: begin
        cur_last = 1'b1;
        cur_err  = (job_q.kind == JOB_ERR_TYPE) ? ERR_TYPE : ERR_CTRL;
      end
      default: ;
    endcase
  end

  assign out_ready = !out_valid_q || pop_i;
  assign emit      = (st_q != ST_IDLE) && out_ready;
  assign load      = (st_q == ST_IDLE) || (emit && cur_last);
  assign job_pop_o = load && job_valid_i;

  // Sequence the bytes of a job and take the next job after the last one
  always_comb begin
    st_d    = st_q;
    job_d   = job_q;
    delay_d = delay_q;
    grp_d   = grp_q;
    pos_d   = pos_q;
    if (load) begin
      if (job_valid_i) begin
        job_d   = job_i;
        delay_d = job_delay_i;
        grp_d   = top_grp;
        pos_d   = 2'd0;
        st_d    = (job_i.kind == JOB_EVENT) ? ST_DELAY : ST_ERR;
      end else begin
        st_d = ST_IDLE;
      end
    end else if (emit) begin
      unique case (st_q)
        ST_DELAY: begin
          if (grp_q == '0) begin
            st_d = job_q.new_chan ? ST_VOL : ST_EVT;
          end else begin
            grp_d = grp_q - 1'b1;
          end
        end
        ST_VOL: begin
          pos_d = pos_q + 2'd1;
          if (pos_q == 2'd3) begin
            st_d = ST_EVT;
          end
        end
        ST_EVT: pos_d = pos_q + 2'd1;
        default: ;
      endcase
    end
  end

  // Fill or drain the output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = cur_byte;
      out_last_d  = cur_last;
      out_err_d   = cur_err;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    delay_q    <= delay_d;
    grp_q      <= grp_d;
    pos_q      <= pos_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign empty_o       = !out_valid_q;
  assign midi_byte_o   = out_byte_q;
  assign last_of_run_o = out_last_q;
  assign error_code_o  = out_err_q;

endmodule
`default_nettype wire
